>>> rtl/crs_pkg.sv
// Package: payload types, configuration, phase and failure codes of the report sender.
`default_nettype none

package crs_pkg;

    localparam int CRS_MAX_SLOTS  = 16;
    localparam int CRS_TIME_BITS  = 32;
    localparam int CRS_CFG_DATA_W = 16;
    localparam int CRS_CFG_IDX_W  = 3;

    localparam logic [CRS_CFG_IDX_W-1:0] CFG_SLOT_TIME    = 3'd0;
    localparam logic [CRS_CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 3'd1;
    localparam logic [CRS_CFG_IDX_W-1:0] CFG_IDLE_CONFIRM = 3'd2;
    localparam logic [CRS_CFG_IDX_W-1:0] CFG_ACK_WAIT     = 3'd3;
    localparam logic [CRS_CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 3'd4;
    localparam logic [CRS_CFG_IDX_W-1:0] CFG_TX_DONE_WAIT = 3'd5;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_WAIT_IDLE = 3'd1;
    localparam logic [2:0] PH_WAIT_SLOT = 3'd2;
    localparam logic [2:0] PH_SEND      = 3'd3;
    localparam logic [2:0] PH_WAIT_TX   = 3'd4;
    localparam logic [2:0] PH_WAIT_ACK  = 3'd5;

    localparam logic [1:0] FAIL_NONE       = 2'd0;
    localparam logic [1:0] FAIL_WRONG_ACK  = 2'd1;
    localparam logic [1:0] FAIL_ACK_TMO    = 2'd2;
    localparam logic [1:0] FAIL_TX_DONE_TMO = 2'd3;

    localparam logic [7:0] RETRY_FOREVER = 8'd255;

    typedef struct packed {
        logic [31:0] now_time;
        logic        tx_done_seen;
        logic        rx_done_seen;
        logic        ack_length_ok;
        logic [15:0] ack_sequence;
        logic        channel_clear;
        logic        mailbox_has_event;
        logic [15:0] mailbox_sequence;
        logic [3:0]  random_slot;
    } crs_poll_t;

    typedef struct packed {
        logic [2:0]  sender_state;
        logic        event_taken;
        logic        start_send;
        logic [15:0] send_sequence;
        logic        ack_accepted;
        logic [1:0]  failure_kind;
        logic        retry_started;
        logic        event_dropped;
        logic        old_replaced;
    } crs_report_t;

    typedef struct packed {
        logic [7:0]  slot_time_ms;
        logic [4:0]  slot_count;
        logic [7:0]  idle_confirm_time_ms;
        logic [15:0] ack_wait_ms;
        logic [7:0]  retry_limit;
        logic [15:0] tx_done_wait_ms;
    } crs_cfg_t;

endpackage

`default_nettype wire

>>> rtl/crs_chan_if.sv
// Interfaces: valid/ready channels for poll items and report items.
`default_nettype none

interface crs_poll_if;
    import crs_pkg::*;

    logic      valid;
    logic      ready;
    crs_poll_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface crs_report_if;
    import crs_pkg::*;

    logic        valid;
    logic        ready;
    crs_report_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/crs_cfg.sv
// Configuration register bank of the report sender.
`default_nettype none

module crs_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [crs_pkg::CRS_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [crs_pkg::CRS_CFG_DATA_W-1:0] cfg_data,
    output crs_pkg::crs_cfg_t                       cfg
);
    import crs_pkg::*;

    crs_cfg_t cfg_reg;
    crs_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOT_TIME:    cfg_next.slot_time_ms         = cfg_data[7:0];
                CFG_SLOT_COUNT:   cfg_next.slot_count           = cfg_data[4:0];
                CFG_IDLE_CONFIRM: cfg_next.idle_confirm_time_ms = cfg_data[7:0];
                CFG_ACK_WAIT:     cfg_next.ack_wait_ms          = cfg_data[15:0];
                CFG_RETRY_LIMIT:  cfg_next.retry_limit          = cfg_data[7:0];
                CFG_TX_DONE_WAIT: cfg_next.tx_done_wait_ms      = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_time_ms         <= 8'd10;
            cfg_reg.slot_count           <= 5'd8;
            cfg_reg.idle_confirm_time_ms <= 8'd20;
            cfg_reg.ack_wait_ms          <= 16'd200;
            cfg_reg.retry_limit          <= 8'd3;
            cfg_reg.tx_done_wait_ms      <= 16'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/crs_core.sv
// Sender state registers and the single-step poll logic.
`default_nettype none

module crs_core #(
    parameter int MAX_SLOTS = crs_pkg::CRS_MAX_SLOTS,
    parameter int TIME_BITS = crs_pkg::CRS_TIME_BITS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire crs_pkg::crs_poll_t poll,
    input  wire crs_pkg::crs_cfg_t  cfg,
    output crs_pkg::crs_report_t result
);
    import crs_pkg::*;

    localparam int NW = ($clog2(MAX_SLOTS + 1) > 5) ? $clog2(MAX_SLOTS + 1) : 5;

    typedef struct packed {
        logic [2:0]           phase;
        logic [TIME_BITS-1:0] entry_time;
        logic                 watch_on;
        logic [TIME_BITS-1:0] watch_start;
        logic [TIME_BITS-1:0] deadline;
        logic                 holding;
        logic [15:0]          held_seq;
        logic [7:0]           retries;
    } state_t;

    typedef struct packed {
        state_t     st;
        logic       taken;
        logic       start;
        logic       ack;
        logic [1:0] fail;
        logic       retry;
        logic       drop;
        logic       repl;
    } work_t;

    state_t state_reg;
    work_t  w;

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] slot_diff;
    logic [NW-1:0]        n_eff;
    logic [3:0]           slot_eff;
    logic [11:0]          slot_delay;

    function automatic work_t go_phase(work_t wi, logic [2:0] p, logic [TIME_BITS-1:0] t);
        work_t wo;
        wo = wi;
        wo.st.phase = p;
        wo.st.entry_time = t;
        return wo;
    endfunction

    function automatic work_t go_rest(work_t wi, logic [2:0] p, logic [TIME_BITS-1:0] t);
        work_t wo;
        wo = go_phase(wi, p, t);
        wo.st.watch_on = 1'b0;
        wo.st.watch_start = '0;
        wo.st.deadline = '0;
        return wo;
    endfunction

    function automatic work_t take_event(work_t wi, crs_poll_t pi);
        work_t wo;
        wo = wi;
        if (pi.mailbox_has_event)
        begin
            if (wi.st.holding)
                wo.repl = 1'b1;
            wo.taken = 1'b1;
            wo.st.held_seq = pi.mailbox_sequence;
            wo.st.holding = 1'b1;
            wo.st.retries = '0;
        end
        return wo;
    endfunction

    function automatic work_t send_failed(work_t wi, crs_poll_t pi, logic [TIME_BITS-1:0] t,
                                          logic [1:0] kind, logic [7:0] limit);
        work_t wo;
        wo = wi;
        wo.fail = kind;
        if (pi.mailbox_has_event)
        begin
            wo = take_event(wo, pi);
            wo = go_rest(wo, PH_WAIT_IDLE, t);
        end
        else if (limit == RETRY_FOREVER || wo.st.retries < limit)
        begin
            if (wo.st.retries != 8'd255)
                wo.st.retries = wo.st.retries + 8'd1;
            wo.retry = 1'b1;
            wo = go_rest(wo, PH_WAIT_IDLE, t);
        end
        else
        begin
            wo.drop = 1'b1;
            wo.st.holding = 1'b0;
            wo = go_rest(wo, PH_IDLE, t);
        end
        return wo;
    endfunction

    assign now = poll.now_time[TIME_BITS-1:0];
    assign slot_diff = now - state_reg.deadline;

    always_comb
    begin
        if (cfg.slot_count == 5'd0)
            n_eff = NW'(1);
        else if (NW'(cfg.slot_count) > NW'(MAX_SLOTS))
            n_eff = NW'(MAX_SLOTS);
        else
            n_eff = NW'(cfg.slot_count);
        if (NW'(poll.random_slot) >= n_eff)
            slot_eff = 4'(n_eff - NW'(1));
        else
            slot_eff = poll.random_slot;
    end

    assign slot_delay = 12'(slot_eff) * 12'(cfg.slot_time_ms);

    always_comb
    begin
        w = '0;
        w.st = state_reg;

        if (poll.tx_done_seen && w.st.phase == PH_WAIT_TX)
            w = go_phase(w, PH_WAIT_ACK, now);

        if (poll.rx_done_seen && w.st.phase == PH_WAIT_ACK)
        begin
            if (poll.ack_length_ok && poll.ack_sequence == w.st.held_seq)
            begin
                w.ack = 1'b1;
                w.st.holding = 1'b0;
                w.st.retries = '0;
                w = go_rest(w, PH_IDLE, now);
            end
            else
            begin
                w = send_failed(w, poll, now, FAIL_WRONG_ACK, cfg.retry_limit);
            end
        end

        case (w.st.phase)
            PH_IDLE:
            begin
                w = take_event(w, poll);
                if (w.st.holding)
                    w = go_rest(w, PH_WAIT_IDLE, now);
            end
            PH_WAIT_IDLE:
            begin
                if (!w.st.holding)
                    w = go_rest(w, PH_IDLE, now);
                else if (poll.channel_clear)
                begin
                    if (!w.st.watch_on)
                    begin
                        w.st.watch_on = 1'b1;
                        w.st.watch_start = now;
                    end
                    else if ((now - w.st.watch_start) >=
                             TIME_BITS'(cfg.idle_confirm_time_ms))
                    begin
                        w.st.watch_on = 1'b0;
                        w.st.deadline = now + TIME_BITS'(slot_delay);
                        w = go_phase(w, PH_WAIT_SLOT, now);
                    end
                end
                else
                begin
                    w.st.watch_on = 1'b0;
                    w.st.watch_start = '0;
                end
            end
            PH_WAIT_SLOT:
            begin
                if (!poll.channel_clear)
                    w = go_rest(w, PH_WAIT_IDLE, now);
                else if (!slot_diff[TIME_BITS-1])
                    w = go_phase(w, PH_SEND, now);
            end
            PH_SEND:
            begin
                if (w.st.holding)
                begin
                    w = take_event(w, poll);
                    w.start = 1'b1;
                    w = go_phase(w, PH_WAIT_TX, now);
                end
                else
                begin
                    w = go_rest(w, PH_IDLE, now);
                end
            end
            PH_WAIT_TX:
            begin
                if ((now - w.st.entry_time) > TIME_BITS'(cfg.tx_done_wait_ms))
                    w = send_failed(w, poll, now, FAIL_TX_DONE_TMO, cfg.retry_limit);
            end
            PH_WAIT_ACK:
            begin
                if ((now - w.st.entry_time) >= TIME_BITS'(cfg.ack_wait_ms))
                    w = send_failed(w, poll, now, FAIL_ACK_TMO, cfg.retry_limit);
            end
            default:
            begin
                w.st.holding = 1'b0;
                w = go_rest(w, PH_IDLE, now);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= w.st;
    end

    always_comb
    begin
        result.sender_state  = w.st.phase;
        result.event_taken   = w.taken;
        result.start_send    = w.start;
        result.send_sequence = w.st.holding ? w.st.held_seq : 16'd0;
        result.ack_accepted  = w.ack;
        result.failure_kind  = w.fail;
        result.retry_started = w.retry;
        result.event_dropped = w.drop;
        result.old_replaced  = w.repl;
    end

endmodule

`default_nettype wire

>>> rtl/contention_report_sender_top.sv
// Top level of the contention report sender: poll register, sender core, report register.
// Each poll item is one step of a CSMA sender with random slot backoff and ACK retry.
// The block sustains one item per clock cycle while the report is not stalled: a poll is
// captured in an input register, the whole step is one pass of compare-and-update logic
// in the sender core, and the report lands in an output register; a stalled report stalls
// at most the single input register behind it. Configuration registers are to be written
// through cfg_we/cfg_index/cfg_data while no item is in flight; the user must keep to
// this, as the block does not enforce it. Indexes outside the register list are ignored.
`default_nettype none

module contention_report_sender_top #(
    parameter int MAX_SLOTS = crs_pkg::CRS_MAX_SLOTS,
    parameter int TIME_BITS = crs_pkg::CRS_TIME_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    crs_poll_if.sink                                poll,
    crs_report_if.source                            report,
    input  wire logic                               cfg_we,
    input  wire logic [crs_pkg::CRS_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [crs_pkg::CRS_CFG_DATA_W-1:0] cfg_data
);
    import crs_pkg::*;

    crs_cfg_t    cfg;
    crs_poll_t   poll_reg;
    logic        poll_valid_reg;
    crs_report_t report_reg;
    logic        report_valid_reg;
    crs_report_t result;
    logic        advance;

    assign advance    = poll_valid_reg && (!report_valid_reg || report.ready);
    assign poll.ready = !poll_valid_reg || advance;

    crs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crs_core #(
        .MAX_SLOTS (MAX_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .poll    (poll_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poll_valid_reg <= 1'b0;
        else if (poll.valid && poll.ready)
            poll_valid_reg <= 1'b1;
        else if (advance)
            poll_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
            poll_reg <= poll.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            report_valid_reg <= 1'b0;
        else if (advance)
            report_valid_reg <= 1'b1;
        else if (report.ready)
            report_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            report_reg <= result;
    end

    assign report.valid = report_valid_reg;
    assign report.data  = report_reg;

endmodule

`default_nettype wire
